// File: design/bpnf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpnf_pkg;

  // Frame geometry
  localparam int WIDTH  = 206;
  localparam int HEIGHT = 156;

  localparam int PIX_W   = 16;
  localparam int ENTRY_W = PIX_W + 1;
  localparam int COL_W   = $clog2(WIDTH);
  localparam int ROW_W   = $clog2(HEIGHT + 1);
  localparam int ADDR_W  = $clog2(2 * WIDTH);
  localparam int SUM_W   = PIX_W + 2;

  // Fixed sensor defect pattern: start of row 0 and per-row step (minus four, mod period)
  localparam int PAT_W      = 4;
  localparam int PAT_PERIOD = 15;
  localparam int PAT_START0 = 10;
  localparam int PAT_STEP   = 11;

  // Parity of the last frame row, the row released by drain transactions
  localparam logic DRAIN_PAR = 1'((HEIGHT - 1) % 2);

  // Job queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // Input function codes
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] pixel_value;
    logic             extra_bad;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] corrected_value;
    logic             frame_last;
  } out_item_t;

  // Stored pixel: bad flag above raw value
  typedef struct packed {
    logic             bad;
    logic [PIX_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             has_result;
    logic             has_up;
    logic             has_below;
    logic             do_write;
    logic             last;
    logic             opar;
    logic [COL_W-1:0] col;
    entry_t           entry;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_A,
    ST_READ_B,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } back_state_t;

endpackage

`default_nettype wire

// File: design/bpnf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bpnf_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire bpnf_pkg::in_item_t item,
  output logic                    job_push,
  output bpnf_pkg::job_t          job
);
  import bpnf_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [PAT_W-1:0] start_r, start_nxt;
  logic [PAT_W-1:0] phase_r, phase_nxt;
  logic             pix_take;
  logic             drain_take;
  logic             advance;
  logic             pat_bad;
  logic [PAT_W:0]   start_sum;

  // Classify the transaction against the frame position
  always_comb begin
    pix_take   = (item.func == FUNC_PIXEL) && (row_r < ROW_W'(HEIGHT));
    drain_take = (item.func == FUNC_DRAIN) && (row_r == ROW_W'(HEIGHT));
    advance    = accept && (pix_take || drain_take);
    pat_bad    = (col_r >= COL_W'(start_r)) && (phase_r == start_r);
  end

  // Build the job for the back end
  always_comb begin
    job_push        = advance;
    job.entry.bad   = item.extra_bad | pat_bad;
    job.entry.value = item.pixel_value;
    job.col         = col_r;
    if (drain_take) begin
      job.has_result = 1'b1;
      job.has_up     = 1'b1;
      job.has_below  = 1'b0;
      job.do_write   = 1'b0;
      job.last       = (col_r == COL_W'(WIDTH - 1));
      job.opar       = DRAIN_PAR;
    end else begin
      job.has_result = (row_r != '0);
      job.has_up     = (row_r >= ROW_W'(2));
      job.has_below  = 1'b1;
      job.do_write   = 1'b1;
      job.last       = 1'b0;
      job.opar       = ~row_r[0];
    end
  end

  // Advance column, row and pattern position
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    start_nxt = start_r;
    phase_nxt = phase_r;
    start_sum = (PAT_W + 1)'(start_r) + (PAT_W + 1)'(PAT_STEP);
    if (advance) begin
      if (col_r == COL_W'(WIDTH - 1)) begin
        col_nxt   = '0;
        phase_nxt = '0;
        if (row_r == ROW_W'(HEIGHT)) begin
          row_nxt   = '0;
          start_nxt = PAT_W'(PAT_START0);
        end else begin
          row_nxt = row_r + ROW_W'(1);
          if (start_sum >= (PAT_W + 1)'(PAT_PERIOD)) begin
            start_nxt = PAT_W'(start_sum - (PAT_W + 1)'(PAT_PERIOD));
          end else begin
            start_nxt = PAT_W'(start_sum);
          end
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
        if (phase_r == PAT_W'(PAT_PERIOD - 1)) begin
          phase_nxt = '0;
        end else begin
          phase_nxt = phase_r + PAT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      start_r <= PAT_W'(PAT_START0);
      phase_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      start_r <= start_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/bpnf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bpnf_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire bpnf_pkg::job_t   push_job,
  input  wire logic             pop,
  output logic                  full,
  output logic                  valid,
  output bpnf_pkg::job_t        head
);
  import bpnf_pkg::*;

  job_t              slots_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  always_comb begin
    full    = (cnt_r == QCNT_W'(Q_DEPTH));
    valid   = (cnt_r != '0);
    head    = slots_r[rd_ptr_r];
    do_push = push && !full;
    do_pop  = pop && valid;
  end

  // Move pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold job payloads
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: design/bpnf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bpnf_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  job_valid,
  input  wire bpnf_pkg::job_t        job,
  output logic                       job_pop,
  input  wire logic [15:0]           fallback,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output bpnf_pkg::out_item_t        out_item
);
  import bpnf_pkg::*;

  localparam int DIV3_SH = SUM_W + 1;
  localparam logic [SUM_W-1:0] DIV3_MUL = SUM_W'(((1 << DIV3_SH) + 1) / 3);

  back_state_t state_r, state_nxt;

  // Two rows of raw pixels with bad flags
  entry_t mem [2 * WIDTH];
  entry_t rdata0_r, rdata1_r;
  entry_t self_r, up_r;

  logic [ADDR_W-1:0] raddr0, raddr1, waddr;
  logic              mem_we;
  logic [COL_W-1:0]  left_col, right_col;

  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [2*SUM_W-1:0] prod;
  logic [PIX_W-1:0]  quot;
  logic [PIX_W-1:0]  res_r, res_nxt;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r;
  logic              out_load;
  logic              slot_free;

  function automatic logic [ADDR_W-1:0] row_addr(input logic par, input logic [COL_W-1:0] c);
    row_addr = par ? ADDR_W'(WIDTH) + ADDR_W'(c) : ADDR_W'(c);
  endfunction

  assign slot_free = !out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (job_valid && job.has_result) begin
          state_nxt = ST_READ_A;
        end
      end
      ST_READ_A: state_nxt = ST_READ_B;
      ST_READ_B: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_DIV;
      ST_DIV:    state_nxt = ST_OUT;
      ST_OUT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Memory addresses, write and job release
  always_comb begin
    left_col  = (job.col == '0) ? job.col : job.col - COL_W'(1);
    right_col = (job.col == COL_W'(WIDTH - 1)) ? job.col : job.col + COL_W'(1);
    raddr0    = row_addr(job.opar, job.col);
    raddr1    = row_addr(~job.opar, job.col);
    waddr     = row_addr(~job.opar, job.col);
    mem_we    = 1'b0;
    job_pop   = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (job_valid && !job.has_result) begin
          mem_we  = 1'b1;
          job_pop = 1'b1;
        end
      end
      ST_READ_B: begin
        raddr0 = row_addr(job.opar, left_col);
        raddr1 = row_addr(job.opar, right_col);
      end
      ST_OUT: begin
        if (slot_free) begin
          mem_we   = job.do_write;
          job_pop  = 1'b1;
          out_load = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Gather good neighbours; left and right sit in the read registers now
  always_comb begin
    sum_nxt = '0;
    cnt_nxt = '0;
    if (job.has_up && !up_r.bad) begin
      sum_nxt = sum_nxt + SUM_W'(up_r.value);
      cnt_nxt = cnt_nxt + 3'd1;
    end
    if (job.has_below && !job.entry.bad) begin
      sum_nxt = sum_nxt + SUM_W'(job.entry.value);
      cnt_nxt = cnt_nxt + 3'd1;
    end
    if ((job.col != '0) && !rdata0_r.bad) begin
      sum_nxt = sum_nxt + SUM_W'(rdata0_r.value);
      cnt_nxt = cnt_nxt + 3'd1;
    end
    if ((job.col != COL_W'(WIDTH - 1)) && !rdata1_r.bad) begin
      sum_nxt = sum_nxt + SUM_W'(rdata1_r.value);
      cnt_nxt = cnt_nxt + 3'd1;
    end
  end

  // Floor average; a third comes from a reciprocal multiply
  always_comb begin
    prod = (2 * SUM_W)'(sum_r) * (2 * SUM_W)'(DIV3_MUL);
    case (cnt_r)
      3'd1:    quot = PIX_W'(sum_r);
      3'd2:    quot = PIX_W'(sum_r >> 1);
      3'd3:    quot = prod[DIV3_SH +: PIX_W];
      3'd4:    quot = PIX_W'(sum_r >> 2);
      default: quot = fallback;
    endcase
    if (!self_r.bad) begin
      res_nxt = self_r.value;
    end else begin
      res_nxt = quot;
    end
  end

  // Output slot
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
    out_empty = !out_valid_r;
    out_item  = out_item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Row memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= job.entry;
    end
    rdata0_r <= mem[raddr0];
    rdata1_r <= mem[raddr1];
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_READ_B) begin
      self_r <= rdata0_r;
      up_r   <= rdata1_r;
    end
    if (state_r == ST_SUM) begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
    if (state_r == ST_DIV) begin
      res_r <= res_nxt;
    end
    if (out_load) begin
      out_item_r.corrected_value <= res_r;
      out_item_r.frame_last      <= job.last;
    end
  end

endmodule

`default_nettype wire

// File: design/bad_pixel_neighbour_fill.sv
`timescale 1ns / 1ps
`default_nettype none

// Bad pixel fill for a 206 x 156 frame streamed in raster order. Each pixel is bad when its
// extra-bad flag is set or it lies on the sensor's fixed diagonal pattern; a bad pixel is
// replaced by the floor average of its good up, down, left and right neighbours, or by the
// fallback register when none is good. Results come out one row late, so push 206 drain
// transactions after the last pixel to flush the final row; frame_last marks its last pixel.
// A first-row pixel is only written to the row memory. A pixel that yields a result runs through
// the back-end sequencer: READ_A and READ_B reads on the two row-memory read ports, a sum, the
// reciprocal-multiply divide and the output load. The front end and a four-deep job queue keep
// accepting meanwhile. The row memory needs no clearing after reset.
module bad_pixel_neighbour_fill (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire bpnf_pkg::in_item_t  in_item,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output bpnf_pkg::out_item_t      out_item,
  input  wire logic                cfg_wr_en,
  input  wire logic [15:0]         cfg_wr_data
);
  import bpnf_pkg::*;

  logic             accept;
  logic             job_push;
  job_t             push_job;
  logic             job_pop;
  logic             job_valid;
  job_t             head_job;
  logic             q_full;
  logic [PIX_W-1:0] fallback_r;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // Hold the fallback value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fallback_r <= '0;
    end else if (cfg_wr_en) begin
      fallback_r <= cfg_wr_data;
    end
  end

  bpnf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .job_push (job_push),
    .job      (push_job)
  );

  bpnf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .full     (q_full),
    .valid    (job_valid),
    .head     (head_job)
  );

  bpnf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (head_job),
    .job_pop   (job_pop),
    .fallback  (fallback_r),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import bpnf_pkg::*;

  localparam int RUN_LIMIT     = 2_000_000;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_REPORTS   = 100;

  // Opening corner of the first frame, columns 0..11 (column 0 in the low bits)
  localparam logic [12*16-1:0] CORNER_VAL = {
    16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFE, 16'h0001,
    16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF
  };
  // Bad clusters that leave some pixels with no good neighbour at all
  localparam logic [11:0] CORNER_BAD_R0 = 12'b0011_1001_0111;
  localparam logic [11:0] CORNER_BAD_R1 = 12'b0111_0010_1011;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_push     = 1'b0;
  logic        in_full;
  in_item_t    in_item     = '0;
  logic        out_empty;
  logic        out_pop     = 1'b0;
  out_item_t   out_item;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  // Predicted state of the block
  entry_t      row_pair [2*WIDTH];
  int unsigned fill_col           = 0;
  int unsigned fill_row           = 0;
  int unsigned defect_start       = PAT_START0;
  int unsigned defect_phase       = 0;
  logic [15:0] no_neighbour_value = '0;

  in_item_t    pending_pixels [$];
  out_item_t   expected_pixels [$];

  int          tx_idle_pct    = 0;
  int          rx_idle_pct    = 0;
  int          mismatches     = 0;
  int          pixels_checked = 0;
  int          hold_left      = 0;
  bit          hold_done      = 1'b0;
  int          cycle_count    = 0;

  bad_pixel_neighbour_fill u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_item     (in_item),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned pair_slot(int unsigned r, int unsigned c);
    return (r % 2) * WIDTH + c;
  endfunction

  // Floor average of the good neighbours of a stored pixel; below is the pixel underneath
  function automatic logic [15:0] neighbour_fill(int unsigned orow, int unsigned c,
                                                 bit has_below, entry_t below);
    entry_t      centre;
    entry_t      nb [4];
    bit          present [4];
    int unsigned sum;
    int unsigned count;
    centre = row_pair[pair_slot(orow, c)];
    if (!centre.bad) return centre.value;
    present[0] = orow > 0;
    nb[0]      = present[0] ? row_pair[pair_slot(orow - 1, c)] : '0;
    present[1] = has_below;
    nb[1]      = below;
    present[2] = c > 0;
    nb[2]      = present[2] ? row_pair[pair_slot(orow, c - 1)] : '0;
    present[3] = c + 1 < WIDTH;
    nb[3]      = present[3] ? row_pair[pair_slot(orow, c + 1)] : '0;
    sum   = 0;
    count = 0;
    for (int i = 0; i < 4; i++) begin
      if (present[i] && !nb[i].bad) begin
        sum += nb[i].value;
        count++;
      end
    end
    if (count == 0) return no_neighbour_value;
    return 16'(sum / count);
  endfunction

  // Advance the raster position and the defect pattern phase
  function automatic void next_column();
    fill_col++;
    defect_phase = (defect_phase + 1) % PAT_PERIOD;
    if (fill_col >= WIDTH) begin
      fill_col     = 0;
      defect_phase = 0;
      fill_row++;
      defect_start = (defect_start + PAT_STEP) % PAT_PERIOD;
      if (fill_row > HEIGHT) begin
        fill_row     = 0;
        defect_start = PAT_START0;
      end
    end
  endfunction

  // Work out the corrected pixel, if any, released by one accepted transaction
  function automatic void predict_fill(in_item_t it);
    entry_t    e;
    out_item_t r;
    if (it.func == FUNC_PIXEL) begin
      if (fill_row >= HEIGHT) return;
      e.bad   = it.extra_bad | (fill_col >= defect_start && defect_phase == defect_start);
      e.value = it.pixel_value;
      if (fill_row > 0) begin
        r.corrected_value = neighbour_fill(fill_row - 1, fill_col, 1'b1, e);
        r.frame_last      = 1'b0;
        expected_pixels   = {expected_pixels, r};
      end
      row_pair[pair_slot(fill_row, fill_col)] = e;
      next_column();
    end else if (fill_row == HEIGHT) begin
      r.corrected_value = neighbour_fill(HEIGHT - 1, fill_col, 1'b0, '0);
      r.frame_last      = fill_col == WIDTH - 1;
      expected_pixels   = {expected_pixels, r};
      next_column();
    end
  endfunction

  task automatic queue_item(logic func, logic [15:0] value, logic xbad);
    in_item_t it;
    it.func        = func;
    it.pixel_value = value;
    it.extra_bad   = xbad;
    pending_pixels = {pending_pixels, it};
  endtask

  // Queue frame rows, each with its own density of bad pixels and value spread
  task automatic queue_rows(int first_row, int last_row, bit with_corner);
    int          bad_pct;
    int          style;
    logic [15:0] value;
    logic        xbad;
    for (int r = first_row; r <= last_row; r++) begin
      case ($urandom_range(4))
        0: bad_pct = 0;
        1: bad_pct = 5;
        2: bad_pct = 30;
        3: bad_pct = 80;
        default: bad_pct = 100;
      endcase
      style = $urandom_range(3);
      for (int c = 0; c < WIDTH; c++) begin
        // stray drain transaction mid-frame, which the block drops
        if ($urandom_range(99) == 0)
          queue_item(FUNC_DRAIN, 16'($urandom), 1'($urandom));
        if (with_corner && r < 2 && c < 12) begin
          value = CORNER_VAL[c*16 +: 16];
          xbad  = (r == 0) ? CORNER_BAD_R0[c] : CORNER_BAD_R1[c];
        end else begin
          case (style)
            0: value = 16'($urandom);
            1: value = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            2: value = 16'hFFFF - 16'($urandom_range(15));
            default: value = 16'($urandom_range(15));
          endcase
          xbad = $urandom_range(99) < bad_pct;
        end
        queue_item(FUNC_PIXEL, value, xbad);
      end
    end
  endtask

  // Flush the last row; pixels slipped in between drain ticks are dropped
  task automatic queue_drain();
    queue_item(FUNC_PIXEL, 16'hFFFF, 1'b1);
    for (int i = 0; i < WIDTH; i++) begin
      if (i > 0 && $urandom_range(49) == 0)
        queue_item(FUNC_PIXEL, 16'($urandom), 1'($urandom));
      queue_item(FUNC_DRAIN, 16'($urandom), 1'($urandom));
    end
  endtask

  // Wait until every transaction is taken and every corrected pixel has come back
  task automatic settle();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_push || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_fallback(logic [15:0] v);
    @(posedge clk);
    cfg_wr_en          <= 1'b1;
    cfg_wr_data        <= v;
    no_neighbour_value  = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Sequence the phases of the run
  initial begin
    tx_idle_pct = 10;
    rx_idle_pct = 75;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    // Sender idles lightly, receiver heavily
    write_fallback(16'hFFFF);
    queue_item(FUNC_DRAIN, 16'hFFFF, 1'b1);
    queue_item(FUNC_DRAIN, 16'h0000, 1'b0);
    queue_rows(0, 51, 1'b1);
    settle();

    // Sender idles heavily, receiver lightly
    tx_idle_pct = 75;
    rx_idle_pct = 10;
    write_fallback(16'h0000);
    queue_rows(52, 103, 1'b0);
    settle();

    // Full rate on both sides through the end of the frame and its drain
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_fallback(16'($urandom));
    queue_rows(104, HEIGHT - 1, 1'b0);
    queue_drain();
    settle();

    // Next frame starts over at row 0 with the pattern at its first-row start
    write_fallback(16'h8001);
    queue_rows(0, 3, 1'b0);
    settle();

    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("** bad_pixel_neighbour_fill: PASSED **");
    end else begin
      $display("** bad_pixel_neighbour_fill: FAILED **");
    end
    $finish;
  end

  // Offer pending transactions; hold each until the block takes it
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full)
        predict_fill(in_item);
      if (!in_push || !in_full) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_item <= pending_pixels.pop_front();
          in_push <= 1'b1;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Compare each popped transaction with the oldest corrected pixel waiting
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        pixels_checked <= pixels_checked + 1;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got value %h last %b",
                     $time, out_item.corrected_value, out_item.frame_last);
        end else begin
          want = expected_pixels.pop_front();
          if (out_item.corrected_value !== want.corrected_value) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: corrected_value expected %h got %h",
                       $time, want.corrected_value, out_item.corrected_value);
          end
          if (out_item.frame_last !== want.frame_last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: frame_last expected %b got %b",
                       $time, want.frame_last, out_item.frame_last);
          end
        end
      end
      out_pop <= hold_left == 0 && $urandom_range(99) >= rx_idle_pct;
    end
  end

  // Hold the receiver off once for a long stretch so the block backs up
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && pixels_checked == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("timeout after %0d cycles", RUN_LIMIT);
    $display("** bad_pixel_neighbour_fill: FAILED **");
    $finish;
  end

endmodule
